>>> rtl/core/ars_pkg.sv
// Package for the adaptive route select block: direction codes, topology codes,
// register indexes and default widths. No dependencies.
package ars_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int QLEN_BITS_DEF  = 10;

   localparam int DIR_BITS       = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int TOPO_BITS      = 2;
   localparam int RING_SIZE_RST  = 8;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_FWD   = 3'd0,
      DIR_BACK  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_DOWN  = 3'd4,
      DIR_UP    = 3'd5
   } dir_type;

   localparam logic [TOPO_BITS-1:0] TOPO_RING = 2'd0;
   localparam logic [TOPO_BITS-1:0] TOPO_GRID = 2'd1;
   localparam logic [TOPO_BITS-1:0] TOPO_CUBE = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TOPOLOGY  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RING_SIZE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OWN_X     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OWN_Y     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OWN_Z     = 3'd4;

endpackage

>>> rtl/core/ars_if.sv
// Request and response channel interfaces of the adaptive route select block.
// Depends on ars_pkg for default widths.
interface ars_req_if #(
   parameter int COORD_BITS = ars_pkg::COORD_BITS_DEF,
   parameter int QLEN_BITS  = ars_pkg::QLEN_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] dest_x;
   logic [COORD_BITS-1:0] dest_y;
   logic [COORD_BITS-1:0] dest_z;
   logic [QLEN_BITS-1:0]  len_forward;
   logic [QLEN_BITS-1:0]  len_back;
   logic [QLEN_BITS-1:0]  len_right;
   logic [QLEN_BITS-1:0]  len_left;
   logic [QLEN_BITS-1:0]  len_down;
   logic [QLEN_BITS-1:0]  len_up;

   modport source (
      output valid, dest_x, dest_y, dest_z,
             len_forward, len_back, len_right, len_left, len_down, len_up,
      input  ready
   );
   modport sink (
      input  valid, dest_x, dest_y, dest_z,
             len_forward, len_back, len_right, len_left, len_down, len_up,
      output ready
   );
endinterface

interface ars_rsp_if #(
   parameter int COORD_BITS = ars_pkg::COORD_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [ars_pkg::DIR_BITS-1:0]  out_dir;
   logic [COORD_BITS-1:0]         hop_x;
   logic [COORD_BITS-1:0]         hop_y;
   logic [COORD_BITS-1:0]         hop_z;
   logic                          at_dest_error;

   modport source (
      output valid, out_dir, hop_x, hop_y, hop_z, at_dest_error,
      input  ready
   );
   modport sink (
      input  valid, out_dir, hop_x, hop_y, hop_z, at_dest_error,
      output ready
   );
endinterface

>>> rtl/core/ars_route.sv
// Route computation: ring shortest-way choice and grid/cube minimal adaptive
// choice by shortest queue. Purely combinational. Depends on ars_pkg.
module ars_route #(
   parameter int COORD_BITS = ars_pkg::COORD_BITS_DEF,
   parameter int QLEN_BITS  = ars_pkg::QLEN_BITS_DEF
) (
   input  logic [ars_pkg::TOPO_BITS-1:0] topology_mode,
   input  logic [COORD_BITS:0]           ring_size,
   input  logic [COORD_BITS-1:0]         own_x,
   input  logic [COORD_BITS-1:0]         own_y,
   input  logic [COORD_BITS-1:0]         own_z,
   input  logic [COORD_BITS-1:0]         dest_x,
   input  logic [COORD_BITS-1:0]         dest_y,
   input  logic [COORD_BITS-1:0]         dest_z,
   input  logic [QLEN_BITS-1:0]          len_forward,
   input  logic [QLEN_BITS-1:0]          len_back,
   input  logic [QLEN_BITS-1:0]          len_right,
   input  logic [QLEN_BITS-1:0]          len_left,
   input  logic [QLEN_BITS-1:0]          len_down,
   input  logic [QLEN_BITS-1:0]          len_up,
   output ars_pkg::dir_type              out_dir,
   output logic [COORD_BITS-1:0]         hop_x,
   output logic [COORD_BITS-1:0]         hop_y,
   output logic [COORD_BITS-1:0]         hop_z,
   output logic                          at_dest_error
);
   import ars_pkg::*;

   logic [COORD_BITS:0]   n_eff;
   logic [COORD_BITS:0]   n_m1;
   logic [COORD_BITS+1:0] n_ext;
   logic [COORD_BITS-1:0] diff_fwd;
   logic [COORD_BITS-1:0] diff_back;
   logic                  x_gt;
   logic                  y_gt;
   logic                  z_gt;
   logic                  ring_fwd;
   logic [COORD_BITS-1:0] ring_hop_x;

   logic                  x_act;
   logic                  y_act;
   logic                  z_act;
   dir_type               x_dir;
   dir_type               y_dir;
   dir_type               z_dir;
   logic [QLEN_BITS-1:0]  x_len;
   logic [QLEN_BITS-1:0]  y_len;
   logic [QLEN_BITS-1:0]  z_len;
   logic                  have;
   dir_type               best_dir;
   logic [QLEN_BITS-1:0]  best_len;

   // ring: shorter way around, compared as 2*distance against ring size
   always_comb begin
      n_eff     = (ring_size == '0) ? (COORD_BITS+1)'(1) : ring_size;
      n_m1      = n_eff - (COORD_BITS+1)'(1);
      n_ext     = {1'b0, n_eff};
      x_gt      = dest_x > own_x;
      diff_fwd  = dest_x - own_x;
      diff_back = own_x - dest_x;
      if (x_gt) begin
         ring_fwd = {1'b0, diff_fwd, 1'b0} <= n_ext;
      end else begin
         ring_fwd = {1'b0, diff_back, 1'b0} > n_ext;
      end
      if (ring_fwd) begin
         ring_hop_x = ({1'b0, own_x} == n_m1) ? '0 : own_x + COORD_BITS'(1);
      end else begin
         ring_hop_x = (own_x == '0) ? n_m1[COORD_BITS-1:0] : own_x - COORD_BITS'(1);
      end
   end

   // grid / cube: candidates in x, y, z order, strictly shorter queue wins
   always_comb begin
      y_gt  = dest_y > own_y;
      z_gt  = dest_z > own_z;
      x_act = dest_x != own_x;
      y_act = dest_y != own_y;
      z_act = (topology_mode != TOPO_GRID) && (dest_z != own_z);
      x_dir = x_gt ? DIR_FWD : DIR_BACK;
      y_dir = y_gt ? DIR_RIGHT : DIR_LEFT;
      z_dir = z_gt ? DIR_DOWN : DIR_UP;
      x_len = x_gt ? len_forward : len_back;
      y_len = y_gt ? len_right : len_left;
      z_len = z_gt ? len_down : len_up;

      have     = 1'b0;
      best_dir = DIR_FWD;
      best_len = '0;
      if (x_act) begin
         have     = 1'b1;
         best_dir = x_dir;
         best_len = x_len;
      end
      if (y_act && (!have || (y_len < best_len))) begin
         have     = 1'b1;
         best_dir = y_dir;
         best_len = y_len;
      end
      if (z_act && (!have || (z_len < best_len))) begin
         have     = 1'b1;
         best_dir = z_dir;
         best_len = z_len;
      end
   end

   always_comb begin
      out_dir       = DIR_FWD;
      hop_x         = own_x;
      hop_y         = own_y;
      hop_z         = own_z;
      at_dest_error = 1'b0;
      if (topology_mode == TOPO_RING) begin
         out_dir = ring_fwd ? DIR_FWD : DIR_BACK;
         hop_x   = ring_hop_x;
      end else if (!have) begin
         at_dest_error = 1'b1;
      end else begin
         out_dir = best_dir;
         case (best_dir)
            DIR_FWD:   hop_x = own_x + COORD_BITS'(1);
            DIR_BACK:  hop_x = own_x - COORD_BITS'(1);
            DIR_RIGHT: hop_y = own_y + COORD_BITS'(1);
            DIR_LEFT:  hop_y = own_y - COORD_BITS'(1);
            DIR_DOWN:  hop_z = own_z + COORD_BITS'(1);
            DIR_UP:    hop_z = own_z - COORD_BITS'(1);
            default: begin
               hop_x = own_x;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/adaptive_route_select.sv
// Adaptive route select top level: config registers, input and result
// registers around ars_route. Depends on ars_pkg, ars_if and ars_route.
//
// One transaction is accepted every cycle while req_ch.ready is high. A result is
// valid on rsp_ch once its request has gone through both registers: the header
// is captured in the input register, the route is worked out in one pass of
// compare-and-select logic and captured in the result register. Results leave
// in request order; a stall on rsp_ch fills the two registers before req_ch.ready
// drops. Configuration is taken on any cycle through csr_we and should change only
// when the block is empty.
module adaptive_route_select #(
   parameter int COORD_BITS = ars_pkg::COORD_BITS_DEF,
   parameter int QLEN_BITS  = ars_pkg::QLEN_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ars_req_if.sink                          req_ch,
   ars_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [ars_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS:0]              csr_wdata
);
   import ars_pkg::*;

   logic [TOPO_BITS-1:0]  topology_ff;
   logic [COORD_BITS:0]   ring_size_ff;
   logic [COORD_BITS-1:0] own_x_ff;
   logic [COORD_BITS-1:0] own_y_ff;
   logic [COORD_BITS-1:0] own_z_ff;

   logic                  s1_v_ff;
   logic                  s1_v_in;
   logic [COORD_BITS-1:0] dest_x_ff;
   logic [COORD_BITS-1:0] dest_y_ff;
   logic [COORD_BITS-1:0] dest_z_ff;
   logic [QLEN_BITS-1:0]  len_forward_ff;
   logic [QLEN_BITS-1:0]  len_back_ff;
   logic [QLEN_BITS-1:0]  len_right_ff;
   logic [QLEN_BITS-1:0]  len_left_ff;
   logic [QLEN_BITS-1:0]  len_down_ff;
   logic [QLEN_BITS-1:0]  len_up_ff;

   logic                  s2_v_ff;
   logic                  s2_v_in;
   dir_type               dir_ff;
   dir_type               dir_in;
   logic [COORD_BITS-1:0] hop_x_ff;
   logic [COORD_BITS-1:0] hop_x_in;
   logic [COORD_BITS-1:0] hop_y_ff;
   logic [COORD_BITS-1:0] hop_y_in;
   logic [COORD_BITS-1:0] hop_z_ff;
   logic [COORD_BITS-1:0] hop_z_in;
   logic                  err_ff;
   logic                  err_in;

   logic                  req_take;
   logic                  s2_load;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff  <= TOPO_RING;
         ring_size_ff <= (COORD_BITS+1)'(RING_SIZE_RST);
         own_x_ff     <= '0;
         own_y_ff     <= '0;
         own_z_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOPOLOGY:  topology_ff  <= csr_wdata[TOPO_BITS-1:0];
            CSR_RING_SIZE: ring_size_ff <= csr_wdata;
            CSR_OWN_X:     own_x_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_OWN_Y:     own_y_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_OWN_Z:     own_z_ff     <= csr_wdata[COORD_BITS-1:0];
            default: begin
               topology_ff <= topology_ff;
            end
         endcase
      end
   end

   // handshake
   assign s2_load      = !s2_v_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_v_ff || s2_load;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_v_in      = req_take || (s1_v_ff && !s2_load);
   assign s2_v_in      = s2_load ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dest_x_ff      <= req_ch.dest_x;
         dest_y_ff      <= req_ch.dest_y;
         dest_z_ff      <= req_ch.dest_z;
         len_forward_ff <= req_ch.len_forward;
         len_back_ff    <= req_ch.len_back;
         len_right_ff   <= req_ch.len_right;
         len_left_ff    <= req_ch.len_left;
         len_down_ff    <= req_ch.len_down;
         len_up_ff      <= req_ch.len_up;
      end
   end

   ars_route #(
      .COORD_BITS (COORD_BITS),
      .QLEN_BITS  (QLEN_BITS)
   ) u_route (
      .topology_mode (topology_ff),
      .ring_size     (ring_size_ff),
      .own_x         (own_x_ff),
      .own_y         (own_y_ff),
      .own_z         (own_z_ff),
      .dest_x        (dest_x_ff),
      .dest_y        (dest_y_ff),
      .dest_z        (dest_z_ff),
      .len_forward   (len_forward_ff),
      .len_back      (len_back_ff),
      .len_right     (len_right_ff),
      .len_left      (len_left_ff),
      .len_down      (len_down_ff),
      .len_up        (len_up_ff),
      .out_dir       (dir_in),
      .hop_x         (hop_x_in),
      .hop_y         (hop_y_in),
      .hop_z         (hop_z_in),
      .at_dest_error (err_in)
   );

   always_ff @(posedge clock) begin
      if (s2_load && s1_v_ff) begin
         dir_ff   <= dir_in;
         hop_x_ff <= hop_x_in;
         hop_y_ff <= hop_y_in;
         hop_z_ff <= hop_z_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_ch.valid         = s2_v_ff;
   assign rsp_ch.out_dir       = dir_ff;
   assign rsp_ch.hop_x         = hop_x_ff;
   assign rsp_ch.hop_y         = hop_y_ff;
   assign rsp_ch.hop_z         = hop_z_ff;
   assign rsp_ch.at_dest_error = err_ff;

   // a stalled input-register transaction is not dropped
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_load |=> s1_v_ff)
      else $error("input register transaction lost under stall");

   // an empty result register never blocks the request side
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !s2_v_ff |-> req_ch.ready)
      else $error("request stalled with empty result register");

   // arrival flag only with the forward code and the own coordinates
   a_err_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.at_dest_error |->
         rsp_ch.out_dir == DIR_FWD && rsp_ch.hop_x == own_x_ff &&
         rsp_ch.hop_y == own_y_ff && rsp_ch.hop_z == own_z_ff)
      else $error("arrival flag with wrong direction or hop");

   // ring mode routes along x only
   a_ring_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && topology_ff == TOPO_RING |->
         (rsp_ch.out_dir == DIR_FWD || rsp_ch.out_dir == DIR_BACK) &&
         !rsp_ch.at_dest_error)
      else $error("ring mode result off the x axis");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_route_select: random and directed packet
// headers under several topologies, checked against an in-bench route predictor.
// Depends on ars_pkg, ars_if and the adaptive_route_select RTL.
module testbench;
   import ars_pkg::*;

   localparam int CW = COORD_BITS_DEF;
   localparam int QW = QLEN_BITS_DEF;
   localparam logic [TOPO_BITS-1:0] TOPO_SPARE = 2'd3;

   typedef struct {
      logic [CW-1:0] dest_x;
      logic [CW-1:0] dest_y;
      logic [CW-1:0] dest_z;
      logic [QW-1:0] len_forward;
      logic [QW-1:0] len_back;
      logic [QW-1:0] len_right;
      logic [QW-1:0] len_left;
      logic [QW-1:0] len_down;
      logic [QW-1:0] len_up;
   } header_type;

   typedef struct {
      dir_type       dir;
      logic [CW-1:0] hop_x;
      logic [CW-1:0] hop_y;
      logic [CW-1:0] hop_z;
      logic          at_dest;
   } route_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CW:0]             csr_wdata;

   ars_req_if #(.COORD_BITS(CW), .QLEN_BITS(QW)) req_ch ();
   ars_rsp_if #(.COORD_BITS(CW))                 rsp_ch ();

   adaptive_route_select #(.COORD_BITS(CW), .QLEN_BITS(QW)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the node configuration
   logic [TOPO_BITS-1:0] topo_mode;
   logic [CW:0]          ring_nodes;
   logic [CW-1:0]        node_x;
   logic [CW-1:0]        node_y;
   logic [CW-1:0]        node_z;

   header_type  header_q[$];
   route_type   route_q[$];
   int unsigned errors;
   int          send_idle_pct;
   int          recv_idle_pct;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic route_type predict_route(header_type h);
      route_type     r;
      int            n;
      int            d;
      int            o;
      logic          fwd;
      logic          have;
      logic [QW-1:0] best;
      dir_type       cand;
      logic [CW-1:0] want_c[3];
      logic [CW-1:0] here_c[3];
      logic [QW-1:0] qlen[6];
      r.dir     = DIR_FWD;
      r.hop_x   = node_x;
      r.hop_y   = node_y;
      r.hop_z   = node_z;
      r.at_dest = 1'b0;
      if (topo_mode == TOPO_RING) begin
         n = (ring_nodes == 0) ? 1 : int'(ring_nodes);
         d = int'(h.dest_x);
         o = int'(node_x);
         if (d > o) begin
            fwd = !((d - o) > (n - d + o));
         end else begin
            fwd = (o - d) > (n - o + d);
         end
         if (fwd) begin
            r.dir   = DIR_FWD;
            r.hop_x = (o == n - 1) ? '0 : CW'(node_x + 1);
         end else begin
            r.dir   = DIR_BACK;
            r.hop_x = (node_x == 0) ? CW'(n - 1) : CW'(node_x - 1);
         end
      end else begin
         want_c[0] = h.dest_x;
         want_c[1] = h.dest_y;
         want_c[2] = h.dest_z;
         here_c[0] = node_x;
         here_c[1] = node_y;
         here_c[2] = node_z;
         qlen[DIR_FWD]   = h.len_forward;
         qlen[DIR_BACK]  = h.len_back;
         qlen[DIR_RIGHT] = h.len_right;
         qlen[DIR_LEFT]  = h.len_left;
         qlen[DIR_DOWN]  = h.len_down;
         qlen[DIR_UP]    = h.len_up;
         have = 1'b0;
         best = '0;
         for (int k = 0; k < 3; k++) begin
            if (want_c[k] != here_c[k] && !(k == 2 && topo_mode == TOPO_GRID)) begin
               cand = dir_type'(2 * k + ((want_c[k] > here_c[k]) ? 0 : 1));
               if (!have || qlen[cand] < best) begin
                  have  = 1'b1;
                  r.dir = cand;
                  best  = qlen[cand];
               end
            end
         end
         if (!have) begin
            r.dir     = DIR_FWD;
            r.at_dest = 1'b1;
         end else begin
            case (r.dir)
               DIR_FWD:   r.hop_x = CW'(node_x + 1);
               DIR_BACK:  r.hop_x = CW'(node_x - 1);
               DIR_RIGHT: r.hop_y = CW'(node_y + 1);
               DIR_LEFT:  r.hop_y = CW'(node_y - 1);
               DIR_DOWN:  r.hop_z = CW'(node_z + 1);
               default:   r.hop_z = CW'(node_z - 1);
            endcase
         end
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] rand_coord(logic [CW-1:0] here);
      case ($urandom_range(5))
         0, 1:    return here;
         2:       return $urandom_range(1) ? CW'(here + 1) : CW'(here - 1);
         3:       return $urandom_range(1) ? {CW{1'b1}} : {CW{1'b0}};
         default: return CW'($urandom_range((1 << CW) - 1));
      endcase
   endfunction

   function automatic logic [QW-1:0] rand_len();
      case ($urandom_range(3))
         0:       return QW'($urandom_range(3));
         1:       return $urandom_range(1) ? {QW{1'b1}} : {QW{1'b0}};
         default: return QW'($urandom_range((1 << QW) - 1));
      endcase
   endfunction

   function automatic header_type make_header();
      header_type h;
      int         n;
      n = (ring_nodes == 0) ? 1 : int'(ring_nodes);
      h.dest_y = rand_coord(node_y);
      h.dest_z = rand_coord(node_z);
      if (topo_mode == TOPO_RING) begin
         case ($urandom_range(4))
            0:       h.dest_x = node_x;
            1:       h.dest_x = CW'($urandom_range(n - 1));
            2:       h.dest_x = CW'(node_x + n / 2);
            default: h.dest_x = rand_coord(node_x);
         endcase
      end else begin
         h.dest_x = rand_coord(node_x);
      end
      h.len_forward = rand_len();
      h.len_back    = rand_len();
      h.len_right   = rand_len();
      h.len_left    = rand_len();
      h.len_down    = rand_len();
      h.len_up      = rand_len();
      return h;
   endfunction

   task automatic push_header(int dx, int dy, int dz, int lf, int lb, int lr, int ll,
                              int ld, int lu);
      header_type h;
      h.dest_x      = CW'(dx);
      h.dest_y      = CW'(dy);
      h.dest_z      = CW'(dz);
      h.len_forward = QW'(lf);
      h.len_back    = QW'(lb);
      h.len_right   = QW'(lr);
      h.len_left    = QW'(ll);
      h.len_down    = QW'(ld);
      h.len_up      = QW'(lu);
      header_q = {header_q, h};
   endtask

   task automatic drain();
      do @(negedge clock);
      while (header_q.size() != 0 || req_ch.valid || route_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CW:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_TOPOLOGY:  topo_mode  = value[TOPO_BITS-1:0];
         CSR_RING_SIZE: ring_nodes = value;
         CSR_OWN_X:     node_x     = value[CW-1:0];
         CSR_OWN_Y:     node_y     = value[CW-1:0];
         CSR_OWN_Z:     node_z     = value[CW-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [TOPO_BITS-1:0] topo, int rsize, int ox, int oy, int oz);
      drain();
      csr_write(CSR_TOPOLOGY, (CW + 1)'(topo));
      csr_write(CSR_RING_SIZE, (CW + 1)'(rsize));
      csr_write(CSR_OWN_X, (CW + 1)'(ox));
      csr_write(CSR_OWN_Y, (CW + 1)'(oy));
      csr_write(CSR_OWN_Z, (CW + 1)'(oz));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int rand_own();
      case ($urandom_range(3))
         0:       return 0;
         1:       return (1 << CW) - 1;
         default: return $urandom_range((1 << CW) - 1);
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      header_type h;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            h.dest_x      = req_ch.dest_x;
            h.dest_y      = req_ch.dest_y;
            h.dest_z      = req_ch.dest_z;
            h.len_forward = req_ch.len_forward;
            h.len_back    = req_ch.len_back;
            h.len_right   = req_ch.len_right;
            h.len_left    = req_ch.len_left;
            h.len_down    = req_ch.len_down;
            h.len_up      = req_ch.len_up;
            route_q = {route_q, predict_route(h)};
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (header_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               h = header_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.dest_x      <= h.dest_x;
               req_ch.dest_y      <= h.dest_y;
               req_ch.dest_z      <= h.dest_z;
               req_ch.len_forward <= h.len_forward;
               req_ch.len_back    <= h.len_back;
               req_ch.len_right   <= h.len_right;
               req_ch.len_left    <= h.len_left;
               req_ch.len_down    <= h.len_down;
               req_ch.len_up      <= h.len_up;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_rsp
      route_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (route_q.size() == 0) begin
               errors++;
               $display("%0t: transaction with no route outstanding, expected none, actual dir %0d",
                        $time, rsp_ch.out_dir);
            end else begin
               want = route_q.pop_front();
               check_field("out_dir", want.dir, rsp_ch.out_dir);
               check_field("hop_x", want.hop_x, rsp_ch.hop_x);
               check_field("hop_y", want.hop_y, rsp_ch.hop_y);
               check_field("hop_z", want.hop_z, rsp_ch.hop_z);
               check_field("at_dest_error", want.at_dest, rsp_ch.at_dest_error);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : main
      int                   rsize;
      int                   ox;
      logic [TOPO_BITS-1:0] topo_seq[12];
      topo_seq = '{TOPO_RING, TOPO_GRID, TOPO_CUBE, TOPO_SPARE,
                   TOPO_CUBE, TOPO_RING, TOPO_GRID, TOPO_RING,
                   TOPO_GRID, TOPO_CUBE, TOPO_RING, TOPO_SPARE};
      errors             = 0;
      send_idle_pct      = 13;
      recv_idle_pct      = 75;
      topo_mode          = TOPO_RING;
      ring_nodes         = RING_SIZE_RST;
      node_x             = '0;
      node_y             = '0;
      node_z             = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      reset              = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ring: arrival, tie going back, wrap forward, destination beyond the ring
      configure(TOPO_RING, 8, 7, 5, 9);
      push_header(7, 0, 0, 0, 0, 0, 0, 0, 0);
      push_header(3, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
      push_header(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_header(1023, 0, 0, 0, 0, 0, 0, 0, 0);
      // ring size zero behaves as a single node
      configure(TOPO_RING, 0, 0, 0, 0);
      push_header(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_header(5, 0, 0, 0, 0, 0, 0, 0, 0);
      // widest ring: back from zero wraps past the coordinate range
      configure(TOPO_RING, 2047, 0, 0, 0);
      push_header(1023, 0, 0, 0, 0, 0, 0, 0, 0);
      push_header(0, 0, 0, 0, 0, 0, 0, 0, 0);
      // forward wrap from the last node, tie with destination below
      configure(TOPO_RING, 1024, 1023, 0, 0);
      push_header(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_header(511, 0, 0, 0, 0, 0, 0, 0, 0);
      // grid: z ignored, all four planar directions, x wins ties
      configure(TOPO_GRID, 8, 512, 512, 512);
      push_header(512, 512, 512, 0, 0, 0, 0, 0, 0);
      push_header(512, 512, 7, 0, 0, 0, 0, 0, 0);
      push_header(1023, 512, 0, 0, 1023, 1023, 1023, 1023, 1023);
      push_header(0, 512, 512, 1023, 1023, 1023, 1023, 1023, 1023);
      push_header(512, 1023, 512, 0, 0, 1023, 0, 0, 0);
      push_header(512, 0, 512, 0, 0, 0, 1023, 0, 0);
      push_header(1023, 1023, 512, 5, 0, 5, 0, 0, 0);
      push_header(1023, 1023, 512, 9, 0, 3, 0, 0, 0);
      // cube: both z directions, shortest queue wins, arrival
      configure(TOPO_CUBE, 8, 512, 512, 512);
      push_header(512, 512, 1023, 0, 0, 0, 0, 1023, 0);
      push_header(512, 512, 0, 0, 0, 0, 0, 0, 1023);
      push_header(0, 0, 0, 1023, 1023, 1023, 1023, 1023, 0);
      push_header(1023, 0, 1023, 0, 0, 0, 0, 0, 0);
      push_header(512, 512, 512, 1023, 1023, 1023, 1023, 1023, 1023);
      // unused topology code acts as cube
      configure(TOPO_SPARE, 8, 0, 1023, 0);
      push_header(0, 1023, 0, 0, 0, 0, 0, 0, 0);
      push_header(1023, 0, 1023, 7, 0, 0, 6, 5, 0);

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(7))
            0:       rsize = 0;
            1:       rsize = 1;
            2:       rsize = 2;
            3:       rsize = 1024;
            4:       rsize = 2047;
            5:       rsize = $urandom_range(3, 16);
            default: rsize = $urandom_range(1, 1024);
         endcase
         ox = rand_own();
         if (topo_seq[ph] == TOPO_RING && $urandom_range(1))
            ox = $urandom_range(((rsize == 0) ? 1 : rsize) - 1) % (1 << CW);
         configure(topo_seq[ph], rsize, ox, rand_own(), rand_own());
         if (ph == 4) begin
            send_idle_pct = 75;
            recv_idle_pct = 13;
         end else if (ph == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (104) header_q = {header_q, make_header()};
      end

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
